[hdl/nnc_pkg.sv]
// Package for the nearest-neighbour n-best classifier.
// Holds sizes, derived widths and the controller state type; no dependencies.
package nnc_pkg;
  localparam int MaxSamples = 4096;
  localparam int Features   = 225;
  localparam int NbestMax   = 16;
  localparam int MaxClasses = 1024;

  localparam int SampleW = $clog2(MaxSamples);
  localparam int FeatW   = 8;
  localparam int FidxW   = 8;
  localparam int ClassW  = $clog2(MaxClasses);
  localparam int StoreDepth = MaxSamples * Features;
  localparam int StoreAw = $clog2(StoreDepth);
  localparam int QAw     = $clog2(Features);
  localparam int SlotW   = $clog2(NbestMax);
  localparam int DistW   = 25;
  localparam int CountW  = SampleW + 1;
  localparam int BestW   = 5;

  localparam logic [DistW-1:0]  DistEmpty = '1;
  localparam logic [ClassW:0]   ClassNone = '1;

  localparam logic          KindLoad  = 1'b0;
  localparam logic          KindQuery = 1'b1;
  localparam logic [0:0]    RegBest   = 1'b0;
  localparam logic [0:0]    RegSamples = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CLEAR, ST_SCAN, ST_LOOK, ST_BUBBLE, ST_EMIT
  } state_t;
endpackage

[hdl/nnc_ram.sv]
// Generic single-port-write, single-read synchronous RAM with registered read.
// No dependencies.
module nnc_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[hdl/nnc_dist.sv]
// Distance accumulator: squares one feature difference per cycle while en is high and sums.
// Depends on nnc_pkg.
module nnc_dist (
  input  logic                       clk,
  input  logic                       clear,
  input  logic                       en,
  input  logic [nnc_pkg::FeatW-1:0]  a,
  input  logic [nnc_pkg::FeatW-1:0]  b,
  output logic [nnc_pkg::DistW-1:0]  sum
);
  logic signed [nnc_pkg::FeatW:0] diff;
  logic [2*nnc_pkg::FeatW-1:0] sq;
  always_comb begin
    diff = $signed({1'b0, a}) - $signed({1'b0, b});
    sq = (2*nnc_pkg::FeatW)'(diff * diff);
  end
  always_ff @(posedge clk) begin
    if (clear) sum <= '0;
    else if (en) sum <= sum + nnc_pkg::DistW'(sq);
  end
endmodule

[hdl/nearest_neighbour_nbest_classifier.sv]
// Nearest-neighbour n-best classifier.
// Input channel (in_valid/in_ready): load items (kind 0) write one training feature
// and the sample's label; query items (kind 1) write one query feature. Items with a
// feature index past the last feature are dropped. The query item at the last feature
// index starts a search over the first sample_count stored samples. While idle, load
// and non-final query items are taken back to back, one per cycle.
// The search first clears the list. Each sample then streams its 225 features from the
// sample RAM and sums the squared differences. After that the sample is either
// rejected, or the n-best list is walked for its class and the new entry is bubbled
// into place among the first slots entries. Here slots is best_count clamped to 1..16.
// Result channel (out_valid/out_ready): the list goes out worst slot first, one
// transfer per cycle while out_ready is high. last marks the final slot, and empty_res
// marks slots that were never filled. With no samples to search, emit follows the clear
// state directly. A stalled receiver holds the current result. No input is taken from
// the final query item until the last result transfer, so the input stalls for the whole
// search and emit.
// Reset returns to idle with best_count 10 and sample_count 0. The sample, label and
// query memories are not cleared. The user must write configuration only while idle; the block does not enforce it.
module nearest_neighbour_nbest_classifier (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [11:0] sample_index,
  input  logic [7:0]  feature_index,
  input  logic [9:0]  class_id,
  input  logic [7:0]  feature_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  rank,
  output logic [9:0]  class_id_out,
  output logic [23:0] distance,
  output logic        empty_res,
  output logic        last
);
  localparam int SW = nnc_pkg::SlotW;
  localparam int DW = nnc_pkg::DistW;
  localparam int CW = nnc_pkg::ClassW;

  logic [nnc_pkg::BestW-1:0]  best_count;
  logic [nnc_pkg::CountW-1:0] sample_count;
  nnc_pkg::state_t state, state_next;

  logic [DW-1:0] bd [nnc_pkg::NbestMax];
  logic [CW:0]   bc [nnc_pkg::NbestMax];

  logic [SW:0] slots;
  logic [nnc_pkg::CountW-1:0] nsamp;
  logic [nnc_pkg::SampleW-1:0] s;
  logic [nnc_pkg::CountW-1:0] s_ext;
  logic [nnc_pkg::QAw-1:0] f;
  logic [nnc_pkg::StoreAw-1:0] base;
  logic rd_valid, rd_last, feed_done;
  logic [SW:0] q;
  logic [SW-1:0] qi, qp;
  logic [CW-1:0] lab;
  logic dist_clear;
  logic hit, reject, last_sample;
  logic sample_done, ins, bub_swap;
  logic [SW-1:0] ins_pos;

  logic in_fire, ld_ok, q_ok, start;
  assign in_fire = in_valid && in_ready;
  assign ld_ok = in_fire && kind == nnc_pkg::KindLoad
      && 32'(feature_index) < nnc_pkg::Features
      && 32'(sample_index) < nnc_pkg::MaxSamples;
  assign q_ok = in_fire && kind == nnc_pkg::KindQuery
      && 32'(feature_index) < nnc_pkg::Features;
  assign start = q_ok && 32'(feature_index) == nnc_pkg::Features - 1;

  logic [nnc_pkg::StoreAw-1:0] wr_addr;
  logic [nnc_pkg::StoreAw-1:0] rd_addr;
  logic [nnc_pkg::FeatW-1:0] srow, qrow;
  logic [CW-1:0] lrow;
  assign wr_addr = nnc_pkg::StoreAw'(sample_index) * nnc_pkg::StoreAw'(nnc_pkg::Features)
      + nnc_pkg::StoreAw'(feature_index);
  assign rd_addr = base + nnc_pkg::StoreAw'(f);

  nnc_ram #(.Width(nnc_pkg::FeatW), .Depth(nnc_pkg::StoreDepth)) u_store (
    .clk, .we(ld_ok), .waddr(wr_addr), .wdata(feature_value),
    .raddr(rd_addr), .rdata(srow));
  nnc_ram #(.Width(CW), .Depth(nnc_pkg::MaxSamples)) u_label (
    .clk, .we(ld_ok), .waddr(sample_index), .wdata(class_id),
    .raddr(s), .rdata(lrow));
  nnc_ram #(.Width(nnc_pkg::FeatW), .Depth(nnc_pkg::Features)) u_query (
    .clk, .we(q_ok), .waddr(feature_index[nnc_pkg::QAw-1:0]), .wdata(feature_value),
    .raddr(f), .rdata(qrow));

  logic [DW-1:0] sum;
  nnc_dist u_dist (.clk, .clear(dist_clear), .en(rd_valid), .a(qrow), .b(srow), .sum);

  always_comb begin
    if (best_count == '0) slots = (SW+1)'(1);
    else if (32'(best_count) > nnc_pkg::NbestMax) slots = (SW+1)'(nnc_pkg::NbestMax);
    else slots = (SW+1)'(best_count);
    nsamp = (32'(sample_count) > nnc_pkg::MaxSamples) ?
        nnc_pkg::CountW'(nnc_pkg::MaxSamples) : sample_count;
    s_ext = nnc_pkg::CountW'(s);
  end

  assign qi = SW'(q);
  assign qp = SW'(q - 1'b1);
  assign hit = bc[qi] == {1'b0, lab};
  // The sum stays valid from the first look cycle until the next sample starts.
  assign reject = sum >= bd[0];
  assign last_sample = s_ext + nnc_pkg::CountW'(1) == nsamp;
  assign in_ready = state == nnc_pkg::ST_IDLE;
  assign out_valid = state == nnc_pkg::ST_EMIT;
  assign dist_clear = state == nnc_pkg::ST_SCAN && !rd_valid;

  always_comb begin
    state_next = state;
    sample_done = 1'b0;
    ins = 1'b0;
    ins_pos = '0;
    bub_swap = 1'b0;
    unique case (state)
      nnc_pkg::ST_IDLE: begin
        if (start) state_next = nnc_pkg::ST_CLEAR;
      end
      nnc_pkg::ST_CLEAR: state_next = (nsamp == '0) ? nnc_pkg::ST_EMIT : nnc_pkg::ST_SCAN;
      nnc_pkg::ST_SCAN: if (rd_last) state_next = nnc_pkg::ST_LOOK;
      nnc_pkg::ST_LOOK: begin
        // A class already in the list is only replaced by a smaller distance;
        // a new class replaces the worst slot.
        if (reject) sample_done = 1'b1;
        else if (hit) begin
          if (sum >= bd[qi]) sample_done = 1'b1;
          else begin
            ins = 1'b1;
            ins_pos = qi;
          end
        end else if (q == slots - 1'b1) ins = 1'b1;
        if (ins) state_next = nnc_pkg::ST_BUBBLE;
      end
      nnc_pkg::ST_BUBBLE: begin
        bub_swap = q < slots && bd[qi] > bd[qp];
        if (!bub_swap) sample_done = 1'b1;
      end
      nnc_pkg::ST_EMIT: begin
        if (out_ready && last) state_next = nnc_pkg::ST_IDLE;
      end
      default: state_next = nnc_pkg::ST_IDLE;
    endcase
    if (sample_done) state_next = last_sample ? nnc_pkg::ST_EMIT : nnc_pkg::ST_SCAN;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nnc_pkg::ST_IDLE;
      best_count <= nnc_pkg::BestW'(10);
      sample_count <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_index == nnc_pkg::RegBest) best_count <= cfg_data[nnc_pkg::BestW-1:0];
        else sample_count <= cfg_data[nnc_pkg::CountW-1:0];
      end
    end
  end

  // Datapath registers; the n-best list is a small set of flops walked one slot a cycle.
  always_ff @(posedge clk) begin
    unique case (state)
      nnc_pkg::ST_CLEAR: begin
        for (int i = 0; i < nnc_pkg::NbestMax; i++) begin
          bd[i] <= nnc_pkg::DistEmpty;
          bc[i] <= nnc_pkg::ClassNone;
        end
        s <= '0; f <= '0; base <= '0; q <= '0;
        rd_valid <= 1'b0; rd_last <= 1'b0; feed_done <= 1'b0;
      end
      nnc_pkg::ST_SCAN: begin
        rd_valid <= !feed_done;
        rd_last <= !feed_done && 32'(f) == nnc_pkg::Features - 1;
        if (!feed_done) begin
          if (32'(f) == nnc_pkg::Features - 1) begin
            f <= '0;
            feed_done <= 1'b1;
          end else f <= f + 1'b1;
        end
        if (rd_last) lab <= lrow;
      end
      nnc_pkg::ST_LOOK: begin
        if (ins) begin
          bd[ins_pos] <= sum;
          bc[ins_pos] <= {1'b0, lab};
          q <= (SW+1)'(ins_pos) + 1'b1;
        end else if (!sample_done) q <= q + 1'b1;
      end
      nnc_pkg::ST_BUBBLE: begin
        if (bub_swap) begin
          bd[qi] <= bd[qp];
          bc[qi] <= bc[qp];
          bd[qp] <= bd[qi];
          bc[qp] <= bc[qi];
          q <= q + 1'b1;
        end
      end
      nnc_pkg::ST_EMIT: begin
        if (out_valid && out_ready) q <= q + 1'b1;
      end
      default: ;
    endcase
    if (sample_done) begin
      s <= s + 1'b1;
      base <= base + nnc_pkg::StoreAw'(nnc_pkg::Features);
      q <= '0;
      feed_done <= 1'b0;
    end
  end

  logic em;
  assign em = bc[qi] == nnc_pkg::ClassNone;
  assign rank = 4'(q);
  assign class_id_out = em ? '0 : bc[qi][CW-1:0];
  assign distance = em ? '0 : (bd[qi] > DW'(24'hFFFFFF) ? 24'hFFFFFF : bd[qi][23:0]);
  assign empty_res = em;
  assign last = q + 1'b1 == slots;
endmodule

[hdl/nnc_checker.sv]
// Port-level checks for the classifier, bound to the top level.
// Depends on nearest_neighbour_nbest_classifier's ports only.
module nnc_checker (
  input logic clk, rst, in_valid, in_ready, out_valid, out_ready, last,
  input logic [3:0] rank
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(rank)) else $error("result dropped");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken during results");
  a_rank: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid && rank == $past(rank) + 4'd1)
    else $error("rank skipped");
  a_first: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> rank == 4'd0) else $error("run not from slot 0");
endmodule

bind nearest_neighbour_nbest_classifier nnc_checker u_chk (.*);
